// File: design/mtfb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtfb_pkg
// Shared types and constants of the telemetry frame builder: frame layout,
// frame kinds, register indexes and the slot carried by each byte cell.
// ----------------------------------------------------------------------------
package mtfb_pkg;

  // frame geometry
  localparam int FRAME_MAX = 17;
  localparam int LEN_W     = 5;
  localparam int PL_START  = 5;
  localparam logic [LEN_W-1:0] FRAME_OVERHEAD = 5'd6;

  // header characters
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_M      = 8'h4D;
  localparam logic [7:0] CH_GT     = 8'h3E;

  // payload sizes
  localparam logic [3:0] SIZE_ATTITUDE = 4'd6;
  localparam logic [3:0] SIZE_ANALOG   = 4'd7;
  localparam logic [3:0] SIZE_STATUS   = 4'd11;
  localparam logic [3:0] SIZE_BOX_IDS  = 4'd3;

  // fixed status payload bytes
  localparam logic [7:0] CYCLE_TIME_HI = 8'h1F;
  localparam logic [7:0] SENSOR_MASK   = 8'hFF;

  // frame kinds
  localparam logic [1:0] FUNC_ATTITUDE = 2'd0;
  localparam logic [1:0] FUNC_ANALOG   = 2'd1;
  localparam logic [1:0] FUNC_STATUS   = 2'd2;
  localparam logic [1:0] FUNC_BOX_IDS  = 2'd3;

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_TELEMETRY_ENABLE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ATTITUDE_COMMAND = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ANALOG_COMMAND   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STATUS_COMMAND   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_IDS_COMMAND  = 3'd4;

  // command register reset values
  localparam logic [7:0] RST_ATTITUDE_COMMAND = 8'd108;
  localparam logic [7:0] RST_ANALOG_COMMAND   = 8'd110;
  localparam logic [7:0] RST_STATUS_COMMAND   = 8'd101;
  localparam logic [7:0] RST_BOX_IDS_COMMAND  = 8'd119;

  // one request as held while waiting for the cell row
  typedef struct packed {
    logic [1:0]         func;
    logic signed [15:0] roll_tenths;
    logic signed [15:0] pitch_tenths;
    logic signed [15:0] yaw_tenths;
    logic [7:0]         volts_tenths;
    logic [15:0]        charge_drawn;
    logic [15:0]        current_tenths;
    logic               is_armed;
    logic               angle_mode;
    logic               horizon_mode;
  } req_t;

  // command codes per frame kind
  typedef struct packed {
    logic [7:0] attitude_command;
    logic [7:0] analog_command;
    logic [7:0] status_command;
    logic [7:0] box_ids_command;
  } cmd_cfg_t;

  // content of one byte cell
  typedef struct packed {
    logic       valid;
    logic       last;
    logic [7:0] data;
  } slot_t;

  // per-cycle control common to every cell
  typedef struct packed {
    logic load;
    logic shift;
  } cell_ctl_t;

endpackage

// File: design/msp_telemetry_frame_builder_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msp_telemetry_frame_builder_top
// Turns telemetry requests into response frames sent as a byte stream
// through a row of byte cells that advances one byte per cycle while out_stall is low.
// ----------------------------------------------------------------------------
//
//  channel  | handshake            | payload
//  ---------+----------------------+---------------------------------------
//  request  | in_valid / in_stall  | func, angles, analog and mode fields
//  frame    | out_valid / out_stall| frame_byte, last_byte
//  config   | cfg_valid / cfg_ready| cfg_index, cfg_data
//
//  A frame of 9 to 17 bytes leaves at one byte per cycle while out_stall is
//  low; the frame length sets the pace, so requests are taken one per frame,
//  with no gap between frames. A request taken while the row is empty waits
//  in the holding register, then loads into the row and shows its first byte.
//  One request waits in a holding register while the row drains; it loads
//  in the cycle the row's final byte leaves.
//  Reset clears the row and the holding register; command codes return to
//  their defaults and telemetry is disabled.
//  Requests taken while telemetry is disabled are dropped.
//
module msp_telemetry_frame_builder_top (
  input  logic               clk,
  input  logic               rst,
  // request channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         func,
  input  logic signed [15:0] roll_tenths,
  input  logic signed [15:0] pitch_tenths,
  input  logic signed [15:0] yaw_tenths,
  input  logic [7:0]         volts_tenths,
  input  logic [15:0]        charge_drawn,
  input  logic [15:0]        current_tenths,
  input  logic               is_armed,
  input  logic               angle_mode,
  input  logic               horizon_mode,
  // frame byte channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         frame_byte,
  output logic               last_byte,
  // configuration channel
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [mtfb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]         cfg_data
);

  logic                telemetry_enable;
  mtfb_pkg::cmd_cfg_t  cmd_cfg;
  logic                pend_valid;
  mtfb_pkg::req_t      pend_req;
  logic                in_accept;
  logic                drain;
  mtfb_pkg::cell_ctl_t ctl;
  mtfb_pkg::slot_t     load_slots [mtfb_pkg::FRAME_MAX];
  mtfb_pkg::slot_t     cell_slots [mtfb_pkg::FRAME_MAX];

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      telemetry_enable         <= 1'b0;
      cmd_cfg.attitude_command <= mtfb_pkg::RST_ATTITUDE_COMMAND;
      cmd_cfg.analog_command   <= mtfb_pkg::RST_ANALOG_COMMAND;
      cmd_cfg.status_command   <= mtfb_pkg::RST_STATUS_COMMAND;
      cmd_cfg.box_ids_command  <= mtfb_pkg::RST_BOX_IDS_COMMAND;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        mtfb_pkg::REG_TELEMETRY_ENABLE: telemetry_enable         <= cfg_data[0];
        mtfb_pkg::REG_ATTITUDE_COMMAND: cmd_cfg.attitude_command <= cfg_data;
        mtfb_pkg::REG_ANALOG_COMMAND:   cmd_cfg.analog_command   <= cfg_data;
        mtfb_pkg::REG_STATUS_COMMAND:   cmd_cfg.status_command   <= cfg_data;
        mtfb_pkg::REG_BOX_IDS_COMMAND:  cmd_cfg.box_ids_command  <= cfg_data;
        default: ;
      endcase
    end
  end

  // row control: advance unless the head byte is held, reload once drained
  assign ctl.shift = !(cell_slots[0].valid && out_stall);
  assign drain     = !cell_slots[1].valid && (!cell_slots[0].valid || !out_stall);
  assign ctl.load  = pend_valid && drain;

  // request holding register
  assign in_stall  = pend_valid && !ctl.load;
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (in_accept) begin
      pend_valid <= telemetry_enable;
    end else if (ctl.load) begin
      pend_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      pend_req <= '{func: func, roll_tenths: roll_tenths, pitch_tenths: pitch_tenths,
                    yaw_tenths: yaw_tenths, volts_tenths: volts_tenths,
                    charge_drawn: charge_drawn, current_tenths: current_tenths,
                    is_armed: is_armed, angle_mode: angle_mode,
                    horizon_mode: horizon_mode};
    end
  end

  // frame layout of the waiting request
  mtfb_frame_gen u_frame_gen (
    .req     (pend_req),
    .cmd_cfg (cmd_cfg),
    .slots   (load_slots)
  );

  // row of byte cells, cell 0 drives the output
  for (genvar k = 0; k < mtfb_pkg::FRAME_MAX; k++) begin : g_cell
    mtfb_pkg::slot_t next_slot;
    if (k == mtfb_pkg::FRAME_MAX - 1) begin : g_tail
      assign next_slot = '0;
    end else begin : g_link
      assign next_slot = cell_slots[k+1];
    end
    mtfb_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctl       (ctl),
      .load_slot (load_slots[k]),
      .next_slot (next_slot),
      .slot      (cell_slots[k])
    );
  end

  // output port
  assign out_valid  = cell_slots[0].valid;
  assign frame_byte = cell_slots[0].data;
  assign last_byte  = cell_slots[0].last;

endmodule

// File: design/mtfb_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtfb_cell
// One byte cell of the output row: loads its byte of a fresh frame or takes
// the byte of its upstream neighbor when the row advances.
// ----------------------------------------------------------------------------
module mtfb_cell (
  input  logic               clk,
  input  logic               rst,
  input  mtfb_pkg::cell_ctl_t ctl,
  input  mtfb_pkg::slot_t    load_slot,
  input  mtfb_pkg::slot_t    next_slot,
  output mtfb_pkg::slot_t    slot
);

  logic       valid;
  logic       last;
  logic [7:0] data;

  // occupancy flag
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctl.load) begin
      valid <= load_slot.valid;
    end else if (ctl.shift) begin
      valid <= next_slot.valid;
    end
  end

  // byte and end marker
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      last <= load_slot.last;
      data <= load_slot.data;
    end else if (ctl.shift) begin
      last <= next_slot.last;
      data <= next_slot.data;
    end
  end

  assign slot = '{valid: valid, last: last, data: data};

endmodule

// File: design/mtfb_frame_gen.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtfb_frame_gen
// Lays out one complete response frame from a request: header, size,
// command, payload and xor checksum, one slot per cell of the row.
// ----------------------------------------------------------------------------
module mtfb_frame_gen (
  input  mtfb_pkg::req_t     req,
  input  mtfb_pkg::cmd_cfg_t cmd_cfg,
  output mtfb_pkg::slot_t    slots [mtfb_pkg::FRAME_MAX]
);

  logic [7:0]                 frame [mtfb_pkg::FRAME_MAX];
  logic [3:0]                 psize;
  logic [7:0]                 crc;
  logic [mtfb_pkg::LEN_W-1:0] total;
  logic [mtfb_pkg::LEN_W-1:0] last_idx;

  // byte layout per frame kind
  always_comb begin
    for (int i = 0; i < mtfb_pkg::FRAME_MAX; i++) begin
      frame[i] = 8'h00;
    end
    frame[0] = mtfb_pkg::CH_DOLLAR;
    frame[1] = mtfb_pkg::CH_M;
    frame[2] = mtfb_pkg::CH_GT;
    case (req.func)
      mtfb_pkg::FUNC_ATTITUDE: begin
        psize    = mtfb_pkg::SIZE_ATTITUDE;
        frame[4] = cmd_cfg.attitude_command;
        frame[5] = req.roll_tenths[7:0];
        frame[6] = req.roll_tenths[15:8];
        frame[7] = req.pitch_tenths[7:0];
        frame[8] = req.pitch_tenths[15:8];
        frame[9] = req.yaw_tenths[7:0];
        frame[10] = req.yaw_tenths[15:8];
      end
      mtfb_pkg::FUNC_ANALOG: begin
        psize     = mtfb_pkg::SIZE_ANALOG;
        frame[4]  = cmd_cfg.analog_command;
        frame[5]  = req.volts_tenths;
        frame[6]  = req.charge_drawn[7:0];
        frame[7]  = req.charge_drawn[15:8];
        frame[10] = req.current_tenths[7:0];
        frame[11] = req.current_tenths[15:8];
      end
      mtfb_pkg::FUNC_STATUS: begin
        psize     = mtfb_pkg::SIZE_STATUS;
        frame[4]  = cmd_cfg.status_command;
        frame[6]  = mtfb_pkg::CYCLE_TIME_HI;
        frame[9]  = mtfb_pkg::SENSOR_MASK;
        frame[10] = mtfb_pkg::SENSOR_MASK;
        frame[11] = {5'b00000, req.horizon_mode, req.angle_mode, req.is_armed};
      end
      default: begin
        psize    = mtfb_pkg::SIZE_BOX_IDS;
        frame[4] = cmd_cfg.box_ids_command;
        frame[6] = 8'd1;
        frame[7] = 8'd2;
      end
    endcase
    frame[3] = {4'b0000, psize};
  end

  // checksum: bytes past the payload are zero, so the xor spans the whole body
  always_comb begin
    crc = 8'h00;
    for (int i = 3; i < mtfb_pkg::FRAME_MAX - 1; i++) begin
      crc = crc ^ frame[i];
    end
  end

  assign total    = {1'b0, psize} + mtfb_pkg::FRAME_OVERHEAD;
  assign last_idx = total - 5'd1;

  // slot per cell, checksum placed right after the payload
  always_comb begin
    for (int i = 0; i < mtfb_pkg::FRAME_MAX; i++) begin
      slots[i].valid = (mtfb_pkg::LEN_W'(i) < total);
      slots[i].last  = (mtfb_pkg::LEN_W'(i) == last_idx);
      slots[i].data  = (mtfb_pkg::LEN_W'(i) == last_idx) ? crc : frame[i];
    end
  end

endmodule

// File: bench/mtfb_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtfb_checker
// Watches the request, frame byte and configuration channels of the frame
// builder, keeps a shadow of its registers, predicts every frame byte of each
// accepted request and compares the byte stream in order.
// ----------------------------------------------------------------------------
module mtfb_checker
  import mtfb_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  // request channel
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  req_t                 req,
  // frame byte channel
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  logic [7:0]           frame_byte,
  input  logic                 last_byte,
  // configuration channel
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data,
  // results for the testbench top
  output int                   fails,
  output int                   pending,
  output int                   bytes_checked
);

  // one expected byte of a frame
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } frame_beat_t;

  frame_beat_t expected_bytes [$];
  logic [7:0]  frame_body [$];
  logic        tlm_enable;
  cmd_cfg_t    cmd_codes;

  function automatic void push_beat(input logic [7:0] data, input logic last);
    frame_beat_t beat;
    beat.data = data;
    beat.last = last;
    expected_bytes.push_back(beat);
  endfunction

  // little-endian 16-bit payload field
  function automatic void add_le16(input logic [15:0] value);
    frame_body.push_back(value[7:0]);
    frame_body.push_back(value[15:8]);
  endfunction

  // size, command and payload bytes, then header, body and xor checksum
  function automatic void predict_frame(input req_t r);
    logic [7:0] csum;
    frame_body.delete();
    case (r.func)
      FUNC_ATTITUDE: begin
        frame_body.push_back({4'd0, SIZE_ATTITUDE});
        frame_body.push_back(cmd_codes.attitude_command);
        add_le16(r.roll_tenths);
        add_le16(r.pitch_tenths);
        add_le16(r.yaw_tenths);
      end
      FUNC_ANALOG: begin
        frame_body.push_back({4'd0, SIZE_ANALOG});
        frame_body.push_back(cmd_codes.analog_command);
        frame_body.push_back(r.volts_tenths);
        add_le16(r.charge_drawn);
        // rssi is always zero
        add_le16(16'h0000);
        add_le16(r.current_tenths);
      end
      FUNC_STATUS: begin
        frame_body.push_back({4'd0, SIZE_STATUS});
        frame_body.push_back(cmd_codes.status_command);
        add_le16({CYCLE_TIME_HI, 8'h00});
        // no i2c errors
        add_le16(16'h0000);
        frame_body.push_back(SENSOR_MASK);
        frame_body.push_back(SENSOR_MASK);
        // 32-bit mode word, then the trailing zero byte
        frame_body.push_back({5'd0, r.horizon_mode, r.angle_mode, r.is_armed});
        repeat (4) frame_body.push_back(8'h00);
      end
      default: begin
        frame_body.push_back({4'd0, SIZE_BOX_IDS});
        frame_body.push_back(cmd_codes.box_ids_command);
        frame_body.push_back(8'd0);
        frame_body.push_back(8'd1);
        frame_body.push_back(8'd2);
      end
    endcase
    push_beat(CH_DOLLAR, 1'b0);
    push_beat(CH_M, 1'b0);
    push_beat(CH_GT, 1'b0);
    csum = 8'h00;
    foreach (frame_body[i]) begin
      csum ^= frame_body[i];
      push_beat(frame_body[i], 1'b0);
    end
    push_beat(csum, 1'b1);
  endfunction

  // compare first, so a byte can never be matched against a request of the same edge
  always @(posedge clk) begin : monitor
    frame_beat_t beat;
    if (rst) begin
      expected_bytes.delete();
      tlm_enable                 = 1'b0;
      cmd_codes.attitude_command = RST_ATTITUDE_COMMAND;
      cmd_codes.analog_command   = RST_ANALOG_COMMAND;
      cmd_codes.status_command   = RST_STATUS_COMMAND;
      cmd_codes.box_ids_command  = RST_BOX_IDS_COMMAND;
    end else begin
      // frame byte transaction
      if (out_valid && !out_stall) begin
        if (expected_bytes.size() == 0) begin
          fails++;
          $error("frame_byte: expected none, actual %02h (last_byte %0b)",
                 frame_byte, last_byte);
        end else begin
          beat = expected_bytes.pop_front();
          bytes_checked++;
          if (frame_byte !== beat.data) begin
            fails++;
            $error("frame_byte: expected %02h, actual %02h", beat.data, frame_byte);
          end
          if (last_byte !== beat.last) begin
            fails++;
            $error("last_byte: expected %0b, actual %0b", beat.last, last_byte);
          end
        end
      end

      // register write transaction, spare indexes change nothing
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_TELEMETRY_ENABLE: tlm_enable                 = cfg_data[0];
          REG_ATTITUDE_COMMAND: cmd_codes.attitude_command = cfg_data;
          REG_ANALOG_COMMAND:   cmd_codes.analog_command   = cfg_data;
          REG_STATUS_COMMAND:   cmd_codes.status_command   = cfg_data;
          REG_BOX_IDS_COMMAND:  cmd_codes.box_ids_command  = cfg_data;
          default: ;
        endcase
      end

      // request transaction, dropped while telemetry is off
      if (in_valid && !in_stall && tlm_enable) begin
        predict_frame(req);
      end
    end
    pending = expected_bytes.size();
  end

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives the telemetry frame builder with directed and random requests over
// several register settings, with bursty requests, a stalling byte sink and
// one long sink hold-off; the checker predicts and compares every frame byte.
// ----------------------------------------------------------------------------
module tb_top;
  import mtfb_pkg::*;

  localparam int SETTLE_CYCLES = 40;
  localparam int LONG_HOLD     = 150;
  localparam int NUM_PHASES    = 6;
  localparam int PHASE_ITEMS   = 20;
  localparam int OFF_ITEMS     = 4;
  localparam int OFF_PHASE     = 3;
  localparam int HOLD_PHASE    = 2;

  // indexes past the last register
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_FIRST = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LAST  = 3'd7;

  // sink stall levels
  localparam int SINK_NONE  = 0;
  localparam int SINK_LIGHT = 1;
  localparam int SINK_HEAVY = 2;

  logic                 clk;
  logic                 rst;
  logic                 in_valid;
  logic                 in_stall;
  req_t                 req;
  logic                 out_valid;
  logic                 out_stall;
  logic [7:0]           frame_byte;
  logic                 last_byte;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [7:0]           cfg_data;

  int fails;
  int pending;
  int bytes_checked;

  // stimulus controls and tallies
  int   sink_mode;
  int   hold_req;
  int   gap_max;
  logic tlm_on;
  int   req_count;
  int   framed_count;
  int   write_count;

  msp_telemetry_frame_builder_top dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .func           (req.func),
    .roll_tenths    (req.roll_tenths),
    .pitch_tenths   (req.pitch_tenths),
    .yaw_tenths     (req.yaw_tenths),
    .volts_tenths   (req.volts_tenths),
    .charge_drawn   (req.charge_drawn),
    .current_tenths (req.current_tenths),
    .is_armed       (req.is_armed),
    .angle_mode     (req.angle_mode),
    .horizon_mode   (req.horizon_mode),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .frame_byte     (frame_byte),
    .last_byte      (last_byte),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  mtfb_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .req           (req),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .frame_byte    (frame_byte),
    .last_byte     (last_byte),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .fails         (fails),
    .pending       (pending),
    .bytes_checked (bytes_checked)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    #2000000;
    $display("tb_top: errors");
    $finish;
  end

  // byte sink: random stall runs, plus one long hold-off on request
  initial begin : frame_sink
    int   run_left;
    int   hold_left;
    int   holds_seen;
    logic stall_now;
    run_left   = 0;
    hold_left  = 0;
    holds_seen = 0;
    stall_now  = 1'b0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (holds_seen != hold_req) begin
        holds_seen = hold_req;
        hold_left  = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        if (run_left == 0) begin
          run_left = $urandom_range(1, 6);
          case (sink_mode)
            SINK_NONE:  stall_now = 1'b0;
            SINK_LIGHT: stall_now = ($urandom_range(0, 3) == 0);
            default:    stall_now = ($urandom_range(0, 1) == 0);
          endcase
        end
        run_left--;
        out_stall <= stall_now;
      end
    end
  end

  // 16-bit value leaning toward the extremes
  function automatic logic [15:0] rand16();
    case ($urandom_range(0, 7))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'h8000;
      3:       return 16'h7FFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] rand_code();
    case ($urandom_range(0, 5))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic req_t rand_req();
    req_t r;
    r.func           = 2'($urandom_range(0, 3));
    r.roll_tenths    = rand16();
    r.pitch_tenths   = rand16();
    r.yaw_tenths     = rand16();
    r.volts_tenths   = rand_code();
    r.charge_drawn   = rand16();
    r.current_tenths = rand16();
    r.is_armed       = 1'($urandom_range(0, 1));
    r.angle_mode     = 1'($urandom_range(0, 1));
    r.horizon_mode   = 1'($urandom_range(0, 1));
    return r;
  endfunction

  function automatic req_t kind_req(input logic [1:0] kind);
    req_t r;
    r      = rand_req();
    r.func = kind;
    return r;
  endfunction

  // one request transaction, valid stays up for a following item
  task automatic send_req(input req_t r);
    in_valid <= 1'b1;
    req      <= r;
    do @(negedge clk); while (in_stall);
    @(posedge clk);
    req_count++;
    if (tlm_on) framed_count++;
  endtask

  // one register write transaction, valid stays up for a following write
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(negedge clk); while (!cfg_ready);
    @(posedge clk);
    write_count++;
    if (idx == REG_TELEMETRY_ENABLE) tlm_on = value[0];
  endtask

  // all frames out, then room for a dropped request to clear the block
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // requests in bursts, with random gaps between bursts when gap_max is nonzero
  task automatic stream_requests(input int count);
    int left;
    int burst;
    left = count;
    while (left > 0) begin
      burst = $urandom_range(1, 8);
      if (burst > left) burst = left;
      repeat (burst) send_req(rand_req());
      left -= burst;
      if (gap_max > 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, gap_max)) @(posedge clk);
      end
    end
  endtask

  // stimulus
  initial begin : stimulus
    req_t r;
    rst          <= 1'b1;
    in_valid     <= 1'b0;
    req          <= '0;
    cfg_valid    <= 1'b0;
    cfg_index    <= REG_TELEMETRY_ENABLE;
    cfg_data     <= 8'h00;
    sink_mode     = SINK_LIGHT;
    hold_req      = 0;
    gap_max       = 0;
    tlm_on        = 1'b0;
    req_count     = 0;
    framed_count  = 0;
    write_count   = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // telemetry is off out of reset: these produce nothing
    send_req(kind_req(FUNC_ATTITUDE));
    send_req(kind_req(FUNC_STATUS));
    wait_idle();

    // enable with extra high bits set, spare indexes must be ignored
    write_reg(REG_TELEMETRY_ENABLE, 8'h03);
    write_reg(REG_SPARE_FIRST, 8'h00);
    write_reg(REG_SPARE_LAST, 8'hAA);
    cfg_valid <= 1'b0;

    // angle extremes
    r = kind_req(FUNC_ATTITUDE);
    r.roll_tenths  = 16'h8000;
    r.pitch_tenths = 16'h7FFF;
    r.yaw_tenths   = 16'hFFFF;
    send_req(r);
    r.roll_tenths  = 16'h0000;
    r.pitch_tenths = 16'h0000;
    r.yaw_tenths   = 16'h0000;
    send_req(r);

    // analog extremes
    r = kind_req(FUNC_ANALOG);
    r.volts_tenths   = 8'hFF;
    r.charge_drawn   = 16'hFFFF;
    r.current_tenths = 16'h0000;
    send_req(r);
    r.volts_tenths   = 8'h00;
    r.charge_drawn   = 16'h0000;
    r.current_tenths = 16'hFFFF;
    send_req(r);

    // mode bits one at a time, none and all
    r = kind_req(FUNC_STATUS);
    {r.horizon_mode, r.angle_mode, r.is_armed} = 3'b000;
    send_req(r);
    {r.horizon_mode, r.angle_mode, r.is_armed} = 3'b001;
    send_req(r);
    {r.horizon_mode, r.angle_mode, r.is_armed} = 3'b010;
    send_req(r);
    {r.horizon_mode, r.angle_mode, r.is_armed} = 3'b100;
    send_req(r);
    {r.horizon_mode, r.angle_mode, r.is_armed} = 3'b111;
    send_req(r);
    send_req(kind_req(FUNC_BOX_IDS));
    wait_idle();

    // command codes at both extremes
    write_reg(REG_ATTITUDE_COMMAND, 8'h00);
    write_reg(REG_ANALOG_COMMAND, 8'hFF);
    write_reg(REG_STATUS_COMMAND, 8'h00);
    write_reg(REG_BOX_IDS_COMMAND, 8'hFF);
    cfg_valid <= 1'b0;
    send_req(kind_req(FUNC_ATTITUDE));
    send_req(kind_req(FUNC_ANALOG));
    send_req(kind_req(FUNC_STATUS));
    send_req(kind_req(FUNC_BOX_IDS));
    wait_idle();
    write_reg(REG_ATTITUDE_COMMAND, 8'hFF);
    write_reg(REG_ANALOG_COMMAND, 8'h00);
    write_reg(REG_STATUS_COMMAND, 8'hFF);
    write_reg(REG_BOX_IDS_COMMAND, 8'h00);
    cfg_valid <= 1'b0;
    send_req(kind_req(FUNC_ATTITUDE));
    send_req(kind_req(FUNC_ANALOG));
    send_req(kind_req(FUNC_STATUS));
    send_req(kind_req(FUNC_BOX_IDS));
    wait_idle();

    // disable with high bits set: only bit 0 counts
    write_reg(REG_TELEMETRY_ENABLE, 8'hFE);
    cfg_valid <= 1'b0;
    send_req(kind_req(FUNC_ANALOG));
    send_req(kind_req(FUNC_BOX_IDS));

    // random phases, each with its own register setting and pacing
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      wait_idle();
      write_reg(REG_ATTITUDE_COMMAND, rand_code());
      write_reg(REG_ANALOG_COMMAND, rand_code());
      write_reg(REG_STATUS_COMMAND, rand_code());
      write_reg(REG_BOX_IDS_COMMAND, rand_code());
      if ($urandom_range(0, 2) == 0) begin
        write_reg(CFG_IDX_W'($urandom_range(REG_SPARE_FIRST, REG_SPARE_LAST)),
                  8'($urandom));
      end
      if (ph == OFF_PHASE) begin
        write_reg(REG_TELEMETRY_ENABLE, {7'($urandom), 1'b0});
      end else begin
        write_reg(REG_TELEMETRY_ENABLE, {7'($urandom), 1'b1});
      end
      cfg_valid <= 1'b0;

      // first phase runs flat out, the hold-off phase keeps offering
      if (ph == 0) begin
        sink_mode = SINK_NONE;
      end else begin
        sink_mode = (ph % 2 == 0) ? SINK_LIGHT : SINK_HEAVY;
      end
      gap_max = (ph == 0 || ph == HOLD_PHASE) ? 0 : 20;
      if (ph == HOLD_PHASE) hold_req++;
      stream_requests((ph == OFF_PHASE) ? OFF_ITEMS : PHASE_ITEMS);
    end

    // drain and verdict
    wait_idle();
    $display("summary: %0d requests, %0d framed over all four kinds, %0d register writes",
             req_count, framed_count, write_count);
    $display("summary: %0d frame bytes compared, one long sink hold-off included",
             bytes_checked);
    if (fails == 0 && pending == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

// File: sim.f
design/mtfb_pkg.sv
design/mtfb_cell.sv
design/mtfb_frame_gen.sv
design/msp_telemetry_frame_builder_top.sv
bench/mtfb_checker.sv
bench/tb_top.sv
